// ===== rtl/core/nct_pkg.sv =====
// Shared widths, codes and control bundles of the neighbour census table.
package nct_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam int KEY_W  = 64;
   localparam int STR_W  = 8;
   localparam int SCNT_W = 16;
   localparam int TOT_W  = 32;
   localparam int DIST_W = 5;
   localparam int OVF_W  = 16;

   localparam logic OP_SIGHT  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic ITEM_ENTRY   = 1'b0;
   localparam logic ITEM_SUMMARY = 1'b1;

   typedef struct packed {
      logic latch_req;
      logic do_match;
      logic do_update;
      logic load_entry;
      logic load_summary;
      logic clear;
   } nct_cmd_type;

   typedef struct packed {
      logic walk_done;
   } nct_sts_type;

endpackage

// ===== rtl/core/nct_ctrl.sv =====
// Sequencer of the neighbour census table: sighting steps, report walk, output valid.
module nct_ctrl
   import nct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output nct_cmd_type cmd,
   input  nct_sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MATCH  = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_WALK   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      req_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd.latch_req = 1'b1;
               state_in      = (req_opcode == OP_REPORT) ? ST_WALK : ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.do_match = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.do_update = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_WALK: begin
            if (out_free) begin
               if (sts.walk_done) begin
                  cmd.load_summary = 1'b1;
                  cmd.clear        = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  cmd.load_entry = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_entry || cmd.load_summary) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/nct_dp.sv =====
// Datapath of the neighbour census table: entry store, key match, counters, output word.
module nct_dp
   import nct_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  nct_cmd_type              cmd,
   output nct_sts_type              sts,
   input  logic        [KEY_W-1:0]  req_device_key,
   input  logic signed [STR_W-1:0]  req_strength,
   input  logic                     req_own_kind,
   output logic                     rsp_item_kind,
   output logic        [KEY_W-1:0]  rsp_entry_key,
   output logic signed [STR_W-1:0]  rsp_best_strength,
   output logic        [SCNT_W-1:0] rsp_sighting_count,
   output logic                     rsp_entry_own_kind,
   output logic        [TOT_W-1:0]  rsp_total_sightings,
   output logic        [TOT_W-1:0]  rsp_own_sightings,
   output logic        [DIST_W-1:0] rsp_distinct_devices,
   output logic        [DIST_W-1:0] rsp_distinct_own,
   output logic        [OVF_W-1:0]  rsp_overflow_count,
   output logic                     rsp_last
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic        [KEY_W-1:0]  key_ff  [TABLE_DEPTH];
   logic signed [STR_W-1:0]  str_ff  [TABLE_DEPTH];
   logic        [SCNT_W-1:0] scnt_ff [TABLE_DEPTH];
   logic                     kind_ff [TABLE_DEPTH];

   logic        [KEY_W-1:0]  req_key_ff;
   logic signed [STR_W-1:0]  req_str_ff;
   logic                     req_own_ff;

   logic                     hit_ff;
   logic        [IDX_W-1:0]  hit_idx_ff;
   logic        [TABLE_DEPTH-1:0] hit_vec;
   logic                     hit_in;
   logic        [IDX_W-1:0]  hit_idx_in;

   logic        [CNT_W-1:0]  fill_ff, fill_in;
   logic        [CNT_W-1:0]  walk_ff, walk_in;
   logic        [CNT_W-1:0]  own_dev_ff, own_dev_in;
   logic        [OVF_W-1:0]  ovf_ff, ovf_in;
   logic        [TOT_W-1:0]  all_ff, all_in;
   logic        [TOT_W-1:0]  own_ff, own_in;

   logic                     full;
   logic        [IDX_W-1:0]  walk_idx;

   assign full          = (fill_ff == CNT_W'(TABLE_DEPTH));
   assign walk_idx      = walk_ff[IDX_W-1:0];
   assign sts.walk_done = (walk_ff == fill_ff);

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_vec[i] = (CNT_W'(i) < fill_ff) && (key_ff[i] == req_key_ff);
      end
      hit_in     = |hit_vec;
      hit_idx_in = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx_in = IDX_W'(i);
         end
      end
   end

   always_comb begin
      fill_in    = fill_ff;
      walk_in    = walk_ff;
      own_dev_in = own_dev_ff;
      ovf_in     = ovf_ff;
      all_in     = all_ff;
      own_in     = own_ff;
      if (cmd.do_update) begin
         all_in = all_ff + TOT_W'(1);
         if (req_own_ff) begin
            own_in = own_ff + TOT_W'(1);
         end
         if (!hit_ff) begin
            if (full) begin
               ovf_in = ovf_ff + OVF_W'(1);
            end else begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
      end
      if (cmd.load_entry) begin
         walk_in = walk_ff + CNT_W'(1);
         if (kind_ff[walk_idx]) begin
            own_dev_in = own_dev_ff + CNT_W'(1);
         end
      end
      if (cmd.clear) begin
         fill_in    = '0;
         walk_in    = '0;
         own_dev_in = '0;
         ovf_in     = '0;
         all_in     = '0;
         own_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         walk_ff    <= '0;
         own_dev_ff <= '0;
         ovf_ff     <= '0;
         all_ff     <= '0;
         own_ff     <= '0;
      end else begin
         fill_ff    <= fill_in;
         walk_ff    <= walk_in;
         own_dev_ff <= own_dev_in;
         ovf_ff     <= ovf_in;
         all_ff     <= all_in;
         own_ff     <= own_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_key_ff <= req_device_key;
         req_str_ff <= req_strength;
         req_own_ff <= req_own_kind;
      end
      if (cmd.do_match) begin
         hit_ff     <= hit_in;
         hit_idx_ff <= hit_idx_in;
      end
      if (cmd.do_update) begin
         if (hit_ff) begin
            if (req_str_ff > str_ff[hit_idx_ff]) begin
               str_ff[hit_idx_ff] <= req_str_ff;
            end
            scnt_ff[hit_idx_ff] <= scnt_ff[hit_idx_ff] + SCNT_W'(1);
         end else if (!full) begin
            key_ff[fill_ff[IDX_W-1:0]]  <= req_key_ff;
            str_ff[fill_ff[IDX_W-1:0]]  <= req_str_ff;
            scnt_ff[fill_ff[IDX_W-1:0]] <= SCNT_W'(1);
            kind_ff[fill_ff[IDX_W-1:0]] <= req_own_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         rsp_item_kind        <= ITEM_ENTRY;
         rsp_entry_key        <= key_ff[walk_idx];
         rsp_best_strength    <= str_ff[walk_idx];
         rsp_sighting_count   <= scnt_ff[walk_idx];
         rsp_entry_own_kind   <= kind_ff[walk_idx];
         rsp_total_sightings  <= '0;
         rsp_own_sightings    <= '0;
         rsp_distinct_devices <= '0;
         rsp_distinct_own     <= '0;
         rsp_overflow_count   <= '0;
         rsp_last             <= 1'b0;
      end else if (cmd.load_summary) begin
         rsp_item_kind        <= ITEM_SUMMARY;
         rsp_entry_key        <= '0;
         rsp_best_strength    <= '0;
         rsp_sighting_count   <= '0;
         rsp_entry_own_kind   <= 1'b0;
         rsp_total_sightings  <= all_ff;
         rsp_own_sightings    <= own_ff;
         rsp_distinct_devices <= DIST_W'(fill_ff);
         rsp_distinct_own     <= DIST_W'(own_dev_ff);
         rsp_overflow_count   <= ovf_ff;
         rsp_last             <= 1'b1;
      end
   end

endmodule

// ===== rtl/core/neighbour_census_table.sv =====
// Neighbour census table: bounded table of heard devices with per-key counters.
//
// req_ channel takes one word per item: opcode 0 records a sighting of
// req_device_key with req_strength and req_own_kind, opcode 1 reports and clears.
// A sighting holds req_stall high after acceptance through the match and
// update states, so no new item is taken until it is done; the key is
// matched against all stored entries in the match state and the entry is
// written in the update state. A report walks the occupied entries one per
// cycle while the output is not stalled and sends an entry word for each in
// slot order, then a summary word with rsp_last high: fill + 1 words, each
// loaded into the output register from the walk state. req_stall stays high
// until the summary word is loaded.
// rsp_ words sit in an output register; while rsp_stall is high the word
// holds and the walk waits. A new item is taken while the summary waits.
// Synchronous reset empties the table, clears all counters and drops any
// pending output word.
module neighbour_census_table
   import nct_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic        [KEY_W-1:0]  req_device_key,
   input  logic signed [STR_W-1:0]  req_strength,
   input  logic                     req_own_kind,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_item_kind,
   output logic        [KEY_W-1:0]  rsp_entry_key,
   output logic signed [STR_W-1:0]  rsp_best_strength,
   output logic        [SCNT_W-1:0] rsp_sighting_count,
   output logic                     rsp_entry_own_kind,
   output logic        [TOT_W-1:0]  rsp_total_sightings,
   output logic        [TOT_W-1:0]  rsp_own_sightings,
   output logic        [DIST_W-1:0] rsp_distinct_devices,
   output logic        [DIST_W-1:0] rsp_distinct_own,
   output logic        [OVF_W-1:0]  rsp_overflow_count,
   output logic                     rsp_last
);

   nct_cmd_type cmd;
   nct_sts_type sts;

   nct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   nct_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_device_key       (req_device_key),
      .req_strength         (req_strength),
      .req_own_kind         (req_own_kind),
      .rsp_item_kind        (rsp_item_kind),
      .rsp_entry_key        (rsp_entry_key),
      .rsp_best_strength    (rsp_best_strength),
      .rsp_sighting_count   (rsp_sighting_count),
      .rsp_entry_own_kind   (rsp_entry_own_kind),
      .rsp_total_sightings  (rsp_total_sightings),
      .rsp_own_sightings    (rsp_own_sightings),
      .rsp_distinct_devices (rsp_distinct_devices),
      .rsp_distinct_own     (rsp_distinct_own),
      .rsp_overflow_count   (rsp_overflow_count),
      .rsp_last             (rsp_last)
   );

`ifndef SYNTHESIS
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_REPORT) |=> req_stall)
      else $error("report accepted but block not busy");

   a_update_after_match: assert property (@(posedge clock) disable iff (reset)
      cmd.do_update |-> $past(cmd.do_match))
      else $error("entry update without a preceding key match");

   a_entry_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_entry |-> !sts.walk_done)
      else $error("entry word loaded past the fill level");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load_summary |=> (rsp_valid && rsp_last && rsp_item_kind == ITEM_SUMMARY))
      else $error("summary word not marked last");
`endif

endmodule
